// ----- src/sclk_pkg.sv -----
`default_nettype none

package sclk_pkg;

   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_REGISTER   = 3'd1,
      CMD_UNREGISTER = 3'd2,
      CMD_IDLE       = 3'd3,
      CMD_RUN        = 3'd4,
      CMD_QUERY      = 3'd5,
      CMD_SLEEP      = 3'd6,
      CMD_CANCEL     = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_EMPTY = 2'd0,
      ST_RUN   = 2'd1,
      ST_SLEEP = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      KIND_ACK    = 3'd0,
      KIND_ID     = 3'd1,
      KIND_TIME   = 3'd2,
      KIND_WAKE   = 3'd3,
      KIND_FULL   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      END_FIXED = 2'd0,
      END_SLEEP = 2'd1,
      END_WAKE  = 2'd2
   } emode_type;

   localparam logic [1:0] REG_TIME_ORIGIN  = 2'd0;
   localparam logic [1:0] REG_IDLE_JUMP    = 2'd1;
   localparam logic [1:0] REG_NO_FORK_MODE = 2'd2;

   typedef struct packed {
      logic [31:0] time_origin;
      logic [31:0] idle_jump;
      logic        no_fork_mode;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] wake;
   } entry_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  slot;
      logic [32:0] reported_time;
      logic [31:0] current_time;
      logic [31:0] run_end;
      emode_type   end_kind;
      logic        run_over;
      logic        all_asleep;
   } rsp_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic rsp_type make_rsp(input kind_type k, input logic [4:0] slot,
                                        input logic [31:0] origin, input logic [31:0] now,
                                        input logic [31:0] etime, input emode_type emode,
                                        input logic [5:0] regc, input logic [5:0] slpc);
      rsp_type r;
      r.kind          = k;
      r.slot          = slot;
      r.reported_time = {1'b0, origin} + {1'b0, now};
      r.current_time  = now;
      r.run_end       = (emode == END_FIXED) ? etime : 32'd0;
      r.end_kind      = emode;
      r.run_over      = (emode == END_FIXED) && (now >= etime);
      r.all_asleep    = (regc == slpc);
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/sclk_ram.sv -----
`default_nettype none

module sclk_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- src/sclk_csr.sv -----
`default_nettype none

module sclk_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output sclk_pkg::cfg_type cfg
);

   sclk_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_paddr[3:2])
            sclk_pkg::REG_TIME_ORIGIN:  cfg_in.time_origin  = csr_pwdata;
            sclk_pkg::REG_IDLE_JUMP:    cfg_in.idle_jump    = csr_pwdata;
            sclk_pkg::REG_NO_FORK_MODE: cfg_in.no_fork_mode = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         sclk_pkg::REG_TIME_ORIGIN:  csr_prdata = cfg_ff.time_origin;
         sclk_pkg::REG_IDLE_JUMP:    csr_prdata = cfg_ff.idle_jump;
         sclk_pkg::REG_NO_FORK_MODE: csr_prdata = {31'd0, cfg_ff.no_fork_mode};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/simulated_clock_sleep_table.sv -----
`default_nettype none

// Simulated clock with a table of SLOTS client slots, each empty, running or
// sleeping until a wake time. One command enters on req_ and gives one primary
// result on rsp_, then one wake notice per sleeper that is due, lowest slot
// first; rsp_tlast marks the final result of the command. The slot table lives
// in a single-port-read synchronous memory, so a command holds the block from
// one acceptance to the next for these steps, and longer while the result side
// stalls: a pipelined read pass over all slots that finds the first free slot,
// the earliest wake time and the addressed client, an execute step, a step to
// form the primary result, then a wake pass that reads each slot, then checks
// it and writes it back, a step to close the command and a return to idle to
// take the next. A new command is taken only when the previous one has handed
// its last result to the output register. Status reads as empty for any slot
// never written since reset; no clearing pass is needed. Configuration:
// time_origin at 0x0, idle_jump at 0x4, no_fork_mode at 0x8; write only while
// the block is idle.

module simulated_clock_sleep_table #(
   parameter int SLOTS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // command[2:0], client[7:3], amount[39:8], run_mode[41:40]
   input  wire logic [47:0]  req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // slot[4:0], reported_time[37:5], current_time[69:38], run_end[101:70],
   // end_kind[103:102], run_over[104], all_asleep[105]
   output logic      [111:0] rsp_tdata,
   // kind[2:0]
   output logic      [2:0]   rsp_tuser,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic      [31:0]  csr_prdata,
   output logic              csr_pready
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int MW = ((IW > 5) ? IW : 5) + 1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_EXEC  = 7'b0000100,
      S_PRIM  = 7'b0001000,
      S_WREAD = 7'b0010000,
      S_WCHK  = 7'b0100000,
      S_FLUSH = 7'b1000000
   } state_type;

   sclk_pkg::cfg_type cfg;

   state_type state_ff, state_in;
   sclk_pkg::cmd_type cmd_ff, cmd_in;
   logic [4:0]  client_ff, client_in;
   logic [31:0] amount_ff, amount_in;
   logic [1:0]  mode_ff, mode_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic        free_found_ff, free_found_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic        best_found_ff, best_found_in;
   logic [31:0] best_wake_ff, best_wake_in;
   sclk_pkg::status_type cli_status_ff, cli_status_in;
   logic [31:0] cli_wake_ff, cli_wake_in;

   logic [31:0] now_ff, now_in;
   logic [31:0] end_ff, end_in;
   sclk_pkg::emode_type emode_ff, emode_in;
   logic [5:0]  regc_ff, regc_in;
   logic [5:0]  slpc_ff, slpc_in;
   logic [SLOTS-1:0] valid_ff, valid_in;

   sclk_pkg::kind_type pkind_ff, pkind_in;
   logic [4:0]  pslot_ff, pslot_in;

   sclk_pkg::rsp_type hold_ff, hold_in;
   logic        hold_valid_ff, hold_valid_in;
   sclk_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   sclk_pkg::entry_type wr_entry, rd_entry;
   logic [33:0] rd_raw;

   logic [IW-1:0] idx;
   sclk_pkg::status_type st;
   logic        out_free;
   logic        cli_ok;
   logic [31:0] t;

   sclk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sclk_ram #(.WIDTH(34), .DEPTH(SLOTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry   = rd_raw;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cli_ok     = (cli_status_ff != sclk_pkg::ST_EMPTY);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {6'd0, rsp_ff.all_asleep, rsp_ff.run_over, rsp_ff.end_kind,
                        rsp_ff.run_end, rsp_ff.current_time, rsp_ff.reported_time,
                        rsp_ff.slot};

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      client_in     = client_ff;
      amount_in     = amount_ff;
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_found_in = best_found_ff;
      best_wake_in  = best_wake_ff;
      cli_status_in = cli_status_ff;
      cli_wake_in   = cli_wake_ff;
      now_in        = now_ff;
      end_in        = end_ff;
      emode_in      = emode_ff;
      regc_in       = regc_ff;
      slpc_in       = slpc_ff;
      valid_in      = valid_ff;
      pkind_in      = pkind_ff;
      pslot_in      = pslot_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_entry      = '0;
      rd_addr       = '0;
      idx           = '0;
      st            = sclk_pkg::ST_EMPTY;
      t             = now_ff;

      // drop the output transaction once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in        = sclk_pkg::cmd_type'(req_tdata[2:0]);
               client_in     = req_tdata[7:3];
               amount_in     = req_tdata[39:8];
               mode_in       = req_tdata[41:40];
               cnt_in        = '0;
               free_found_in = 1'b0;
               best_found_in = 1'b0;
               cli_status_in = sclk_pkg::ST_EMPTY;
               state_in      = S_SCAN;
            end
         end

         S_SCAN: begin
            // issue read for slot cnt, look at data of slot cnt-1
            if (cnt_ff != CW'(SLOTS)) begin
               rd_addr = cnt_ff[IW-1:0];
            end
            if (cnt_ff != '0) begin
               idx = IW'(cnt_ff - CW'(1));
               st  = valid_ff[idx] ? rd_entry.status : sclk_pkg::ST_EMPTY;
               if (st == sclk_pkg::ST_EMPTY && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx;
               end
               if (st == sclk_pkg::ST_SLEEP &&
                   (!best_found_ff || rd_entry.wake < best_wake_ff)) begin
                  best_found_in = 1'b1;
                  best_wake_in  = rd_entry.wake;
               end
               if (MW'(idx) == MW'(client_ff)) begin
                  cli_status_in = st;
                  cli_wake_in   = rd_entry.wake;
               end
            end
            if (cnt_ff == CW'(SLOTS)) begin
               state_in = S_EXEC;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end

         S_EXEC: begin
            pkind_in = sclk_pkg::KIND_ACK;
            pslot_in = client_ff;
            case (cmd_ff)
               sclk_pkg::CMD_REGISTER: begin
                  if (!free_found_ff) begin
                     pkind_in = sclk_pkg::KIND_FULL;
                     pslot_in = 5'd0;
                  end else begin
                     wr_en           = 1'b1;
                     wr_addr         = free_idx_ff;
                     wr_entry.status = sclk_pkg::ST_RUN;
                     wr_entry.wake   = 32'd0;
                     valid_in[free_idx_ff] = 1'b1;
                     regc_in  = regc_ff + 6'd1;
                     pkind_in = sclk_pkg::KIND_ID;
                     pslot_in = 5'(free_idx_ff);
                  end
               end
               sclk_pkg::CMD_UNREGISTER: begin
                  if (cli_ok) begin
                     if (cli_status_ff == sclk_pkg::ST_SLEEP) slpc_in = slpc_ff - 6'd1;
                     wr_en           = 1'b1;
                     wr_addr         = IW'(client_ff);
                     wr_entry.status = sclk_pkg::ST_EMPTY;
                     wr_entry.wake   = cli_wake_ff;
                     regc_in         = regc_ff - 6'd1;
                     if (emode_ff == sclk_pkg::END_SLEEP) begin
                        emode_in = sclk_pkg::END_FIXED;
                        end_in   = now_ff;
                     end
                  end
               end
               sclk_pkg::CMD_IDLE: begin
                  if (cfg.idle_jump != 32'd0) begin
                     t = sclk_pkg::sat_add(now_ff, cfg.idle_jump);
                     if (emode_ff == sclk_pkg::END_FIXED && t >= end_ff) t = end_ff;
                     if (best_found_ff && t > best_wake_ff) t = best_wake_ff;
                     now_in = t;
                  end else if (best_found_ff &&
                               (emode_ff != sclk_pkg::END_FIXED || best_wake_ff <= end_ff)) begin
                     now_in = best_wake_ff;
                  end else if (emode_ff == sclk_pkg::END_FIXED) begin
                     now_in = end_ff;
                  end else if (cfg.no_fork_mode) begin
                     emode_in = sclk_pkg::END_FIXED;
                     end_in   = now_ff;
                  end
               end
               sclk_pkg::CMD_RUN: begin
                  if (mode_ff == sclk_pkg::END_SLEEP || mode_ff == sclk_pkg::END_WAKE) begin
                     emode_in = sclk_pkg::emode_type'(mode_ff);
                  end else if (emode_ff == sclk_pkg::END_FIXED) begin
                     end_in = sclk_pkg::sat_add(end_ff, amount_ff);
                  end else begin
                     end_in   = sclk_pkg::sat_add(now_ff, amount_ff);
                     emode_in = sclk_pkg::END_FIXED;
                  end
               end
               sclk_pkg::CMD_QUERY: begin
                  pkind_in = sclk_pkg::KIND_TIME;
               end
               sclk_pkg::CMD_SLEEP: begin
                  if (cli_ok) begin
                     if (cli_status_ff != sclk_pkg::ST_SLEEP) slpc_in = slpc_ff + 6'd1;
                     wr_en           = 1'b1;
                     wr_addr         = IW'(client_ff);
                     wr_entry.status = sclk_pkg::ST_SLEEP;
                     wr_entry.wake   = sclk_pkg::sat_add(now_ff, amount_ff);
                     if (emode_ff == sclk_pkg::END_SLEEP) begin
                        emode_in = sclk_pkg::END_FIXED;
                        end_in   = now_ff;
                     end
                  end
               end
               sclk_pkg::CMD_CANCEL: begin
                  if (cli_ok) begin
                     if (cli_status_ff == sclk_pkg::ST_SLEEP) slpc_in = slpc_ff - 6'd1;
                     wr_en           = 1'b1;
                     wr_addr         = IW'(client_ff);
                     wr_entry.status = sclk_pkg::ST_RUN;
                     wr_entry.wake   = cli_wake_ff;
                     pkind_in        = sclk_pkg::KIND_WAKE;
                  end
               end
               default: ;
            endcase
            state_in = S_PRIM;
         end

         S_PRIM: begin
            // primary result waits in the hold stage until we know if it is last
            hold_in = sclk_pkg::make_rsp(pkind_ff, pslot_ff, cfg.time_origin, now_ff,
                                         end_ff, emode_ff, regc_ff, slpc_ff);
            hold_valid_in = 1'b1;
            cnt_in        = '0;
            state_in      = S_WREAD;
         end

         S_WREAD: begin
            rd_addr  = cnt_ff[IW-1:0];
            state_in = S_WCHK;
         end

         S_WCHK: begin
            idx     = cnt_ff[IW-1:0];
            rd_addr = idx;
            st      = valid_ff[idx] ? rd_entry.status : sclk_pkg::ST_EMPTY;
            if (st == sclk_pkg::ST_SLEEP && rd_entry.wake <= now_ff) begin
               if (out_free) begin
                  wr_en           = 1'b1;
                  wr_addr         = idx;
                  wr_entry.status = sclk_pkg::ST_RUN;
                  wr_entry.wake   = rd_entry.wake;
                  slpc_in         = slpc_ff - 6'd1;
                  if (emode_ff == sclk_pkg::END_WAKE) begin
                     emode_in = sclk_pkg::END_FIXED;
                     end_in   = sclk_pkg::sat_add(now_ff, 32'd1);
                  end
                  rsp_in       = hold_ff;
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b0;
                  hold_in = sclk_pkg::make_rsp(sclk_pkg::KIND_WAKE, 5'(idx), cfg.time_origin,
                                               now_ff, end_in, emode_in, regc_ff, slpc_in);
                  cnt_in   = cnt_ff + CW'(1);
                  state_in = (cnt_ff == CW'(SLOTS - 1)) ? S_FLUSH : S_WREAD;
               end
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = (cnt_ff == CW'(SLOTS - 1)) ? S_FLUSH : S_WREAD;
            end
         end

         S_FLUSH: begin
            if (out_free) begin
               rsp_in        = hold_ff;
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         now_ff        <= '0;
         end_ff        <= '0;
         emode_ff      <= sclk_pkg::END_FIXED;
         regc_ff       <= '0;
         slpc_ff       <= '0;
         valid_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         end_ff        <= end_in;
         emode_ff      <= emode_in;
         regc_ff       <= regc_in;
         slpc_ff       <= slpc_in;
         valid_ff      <= valid_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      client_ff     <= client_in;
      amount_ff     <= amount_in;
      mode_ff       <= mode_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_found_ff <= best_found_in;
      best_wake_ff  <= best_wake_in;
      cli_status_ff <= cli_status_in;
      cli_wake_ff   <= cli_wake_in;
      pkind_ff      <= pkind_in;
      pslot_ff      <= pslot_in;
      hold_ff       <= hold_in;
      rsp_ff        <= rsp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   a_counts: assert property (@(posedge clock) disable iff (reset)
      slpc_ff <= regc_ff && regc_ff <= 6'(SLOTS))
      else $error("sleeping or registered count out of range");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !hold_valid_ff)
      else $error("new command taken while a result is held");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && out_free) |=> (rsp_tvalid && rsp_tlast && req_tready))
      else $error("command closed without a last result");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(SLOTS))
      else $error("slot counter beyond table");

endmodule

`default_nettype wire

// ----- test/sclk_table_checker.sv -----
`default_nettype none

module sclk_table_checker #(
   parameter int SLOTS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [47:0]  req_tdata,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [111:0] rsp_tdata,
   input  wire logic [2:0]   rsp_tuser,
   input  wire logic         rsp_tlast,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   input  wire logic         csr_pready,
   output int                error_count,
   output int                outstanding
);

   typedef struct {
      sclk_pkg::kind_type  kind;
      logic [4:0]          slot;
      logic [32:0]         reported;
      logic [31:0]         now;
      logic [31:0]         run_end;
      sclk_pkg::emode_type end_kind;
      logic                run_over;
      logic                all_asleep;
      logic                last;
   } notice_type;

   notice_type  expected_notices[$];

   logic [31:0] origin_q, jump_q;
   logic        no_fork_q;
   sclk_pkg::status_type slot_state[SLOTS];
   logic [31:0] slot_wake[SLOTS];
   logic [31:0] sim_now, end_at;
   sclk_pkg::emode_type end_how;
   int          n_registered, n_sleeping;

   assign outstanding = expected_notices.size();

   function automatic logic [31:0] clamp_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void queue_notice(sclk_pkg::kind_type k, logic [4:0] sl);
      notice_type n;
      n.kind       = k;
      n.slot       = sl;
      n.reported   = {1'b0, origin_q} + {1'b0, sim_now};
      n.now        = sim_now;
      n.run_end    = (end_how == sclk_pkg::END_FIXED) ? end_at : 32'd0;
      n.end_kind   = end_how;
      n.run_over   = (end_how == sclk_pkg::END_FIXED) && (sim_now >= end_at);
      n.all_asleep = (n_registered == n_sleeping);
      n.last       = 1'b0;
      expected_notices.push_back(n);
   endfunction

   // earliest sleeper, lowest slot on ties; -1 if none
   function automatic int soonest_sleeper();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
         if (slot_state[i] == sclk_pkg::ST_SLEEP &&
             (best < 0 || slot_wake[i] < slot_wake[best]))
            best = i;
      return best;
   endfunction

   function automatic void close_on_sleep();
      if (end_how == sclk_pkg::END_SLEEP) begin
         end_how = sclk_pkg::END_FIXED;
         end_at  = sim_now;
      end
   endfunction

   function automatic void advance_idle();
      int          n;
      logic [31:0] t;
      n = soonest_sleeper();
      if (jump_q != 0) begin
         t = clamp_sum(sim_now, jump_q);
         if (end_how == sclk_pkg::END_FIXED && t >= end_at) t = end_at;
         if (n >= 0 && t > slot_wake[n]) t = slot_wake[n];
         sim_now = t;
      end else if (n >= 0 &&
                   (end_how != sclk_pkg::END_FIXED || slot_wake[n] <= end_at)) begin
         sim_now = slot_wake[n];
      end else if (end_how == sclk_pkg::END_FIXED) begin
         sim_now = end_at;
      end else if (no_fork_q) begin
         end_how = sclk_pkg::END_FIXED;
         end_at  = sim_now;
      end
   endfunction

   function automatic void predict_command(logic [47:0] d);
      sclk_pkg::cmd_type  cmd;
      logic [4:0]         c;
      logic [31:0]        amt;
      logic [1:0]         md;
      logic               known;
      sclk_pkg::kind_type k;
      logic [4:0]         sl;
      int                 free;
      cmd   = sclk_pkg::cmd_type'(d[2:0]);
      c     = d[7:3];
      amt   = d[39:8];
      md    = d[41:40];
      known = (c < SLOTS) && (slot_state[c] != sclk_pkg::ST_EMPTY);
      k     = sclk_pkg::KIND_ACK;
      sl    = c;
      case (cmd)
         sclk_pkg::CMD_REGISTER: begin
            free = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (slot_state[i] == sclk_pkg::ST_EMPTY) free = i;
            if (free < 0) begin
               k  = sclk_pkg::KIND_FULL;
               sl = '0;
            end else begin
               slot_state[free] = sclk_pkg::ST_RUN;
               n_registered++;
               k  = sclk_pkg::KIND_ID;
               sl = free[4:0];
            end
         end
         sclk_pkg::CMD_UNREGISTER: if (known) begin
            if (slot_state[c] == sclk_pkg::ST_SLEEP) n_sleeping--;
            slot_state[c] = sclk_pkg::ST_EMPTY;
            n_registered--;
            close_on_sleep();
         end
         sclk_pkg::CMD_IDLE: advance_idle();
         sclk_pkg::CMD_RUN: begin
            if (md == 2'd1 || md == 2'd2) begin
               end_how = sclk_pkg::emode_type'(md);
            end else if (end_how == sclk_pkg::END_FIXED) begin
               end_at = clamp_sum(end_at, amt);
            end else begin
               end_at  = clamp_sum(sim_now, amt);
               end_how = sclk_pkg::END_FIXED;
            end
         end
         sclk_pkg::CMD_QUERY: k = sclk_pkg::KIND_TIME;
         sclk_pkg::CMD_SLEEP: if (known) begin
            if (slot_state[c] != sclk_pkg::ST_SLEEP) n_sleeping++;
            slot_state[c] = sclk_pkg::ST_SLEEP;
            slot_wake[c]  = clamp_sum(sim_now, amt);
            close_on_sleep();
         end
         sclk_pkg::CMD_CANCEL: if (known) begin
            if (slot_state[c] == sclk_pkg::ST_SLEEP) n_sleeping--;
            slot_state[c] = sclk_pkg::ST_RUN;
            k = sclk_pkg::KIND_WAKE;
         end
         default: ;
      endcase
      queue_notice(k, sl);
      // wake every due sleeper, in slot order
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_state[i] == sclk_pkg::ST_SLEEP && slot_wake[i] <= sim_now) begin
            slot_state[i] = sclk_pkg::ST_RUN;
            n_sleeping--;
            if (end_how == sclk_pkg::END_WAKE) begin
               end_how = sclk_pkg::END_FIXED;
               end_at  = clamp_sum(sim_now, 32'd1);
            end
            queue_notice(sclk_pkg::KIND_WAKE, i[4:0]);
         end
      end
      expected_notices[$].last = 1'b1;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      notice_type n;
      if (reset) begin
         origin_q  = '0;
         jump_q    = '0;
         no_fork_q = 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_state[i] = sclk_pkg::ST_EMPTY;
            slot_wake[i]  = '0;
         end
         sim_now      = '0;
         end_at       = '0;
         end_how      = sclk_pkg::END_FIXED;
         n_registered = 0;
         n_sleeping   = 0;
         expected_notices.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[1:0] == 2'b00) begin
            case (csr_paddr[3:2])
               sclk_pkg::REG_TIME_ORIGIN:  origin_q  = csr_pwdata;
               sclk_pkg::REG_IDLE_JUMP:    jump_q    = csr_pwdata;
               sclk_pkg::REG_NO_FORK_MODE: no_fork_q = csr_pwdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_notices.size() == 0) begin
               report_mismatch("unexpected result, kind", rsp_tuser, 0);
            end else begin
               n = expected_notices.pop_front();
               if (sclk_pkg::kind_type'(rsp_tuser) != n.kind)
                  report_mismatch("kind", rsp_tuser, n.kind);
               if (rsp_tdata[4:0] != n.slot) report_mismatch("slot", rsp_tdata[4:0], n.slot);
               if (rsp_tdata[37:5] != n.reported)
                  report_mismatch("reported_time", rsp_tdata[37:5], n.reported);
               if (rsp_tdata[69:38] != n.now)
                  report_mismatch("current_time", rsp_tdata[69:38], n.now);
               if (rsp_tdata[101:70] != n.run_end)
                  report_mismatch("run_end", rsp_tdata[101:70], n.run_end);
               if (rsp_tdata[103:102] != n.end_kind)
                  report_mismatch("end_kind", rsp_tdata[103:102], n.end_kind);
               if (rsp_tdata[104] != n.run_over)
                  report_mismatch("run_over", rsp_tdata[104], n.run_over);
               if (rsp_tdata[105] != n.all_asleep)
                  report_mismatch("all_asleep", rsp_tdata[105], n.all_asleep);
               if (rsp_tlast != n.last) report_mismatch("last", rsp_tlast, n.last);
            end
         end
         if (req_tvalid && req_tready) predict_command(req_tdata);
      end
   end

endmodule

`default_nettype wire

// ----- test/tb_simulated_clock_sleep_table.sv -----
`default_nettype none

module tb_simulated_clock_sleep_table;

   localparam int SETTLE_CYCLES = 150;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_ITEMS   = 80;

   logic         clock;
   logic         reset;
   logic [47:0]  req_tdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_psel, csr_penable, csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           error_count;
   int           outstanding;

   // calm: no idling on either side; hold_request: ask the receiver for a long hold-off
   logic         calm;
   logic         hold_request;
   int           hold_left;
   int           cycle_count;

   simulated_clock_sleep_table dut (.*);

   sclk_table_checker checker_i (
      .clock, .reset, .req_tdata, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tuser, .rsp_tlast, .rsp_tvalid, .rsp_tready,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .error_count, .outstanding
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: abandon the run, reporting errors, once the cycle counter passes CYCLE_LIMIT
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // result side: random back-pressure, or a long counted hold-off on request
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 38);
         end
      end
   end

   // offer one transaction and hold it until accepted; then perhaps drop valid for a while
   task automatic send_command(sclk_pkg::cmd_type c, logic [4:0] cl, logic [31:0] amt,
                               logic [1:0] md);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, md, amt, cl, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!calm && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // drop valid, wait for every expected transaction, then let the block close its command
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_amount();
      case ($urandom_range(3))
         0:       return $urandom_range(0, 3);
         1:       return $urandom_range(0, 40);
         2:       return $urandom_range(0, 100000);
         default: return $urandom;
      endcase
   endfunction

   // weighted command mix; fill_bias favours registration to reach a full table
   task automatic send_random(bit fill_bias);
      int                w;
      sclk_pkg::cmd_type c;
      logic [4:0]        cl;
      w = $urandom_range(99);
      if (fill_bias && w < 55)  c = sclk_pkg::CMD_REGISTER;
      else if (w < 14)          c = sclk_pkg::CMD_REGISTER;
      else if (w < 21)          c = sclk_pkg::CMD_UNREGISTER;
      else if (w < 41)          c = sclk_pkg::CMD_IDLE;
      else if (w < 53)          c = sclk_pkg::CMD_RUN;
      else if (w < 60)          c = sclk_pkg::CMD_QUERY;
      else if (w < 85)          c = sclk_pkg::CMD_SLEEP;
      else if (w < 94)          c = sclk_pkg::CMD_CANCEL;
      else                      c = sclk_pkg::CMD_NONE;
      // mostly slots likely to be in use, sometimes any slot
      cl = ($urandom_range(99) < 80) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
      send_command(c, cl, pick_amount(), 2'($urandom_range(0, 3)));
   endtask

   initial begin
      logic [31:0] origins[6];
      logic [31:0] jumps[6];
      logic        forks[6];
      origins = '{32'd0, $urandom, 32'hFFFF_FFFF, $urandom, 32'd0, 32'hFFFF_FFFF};
      jumps   = '{32'd0, 32'd0, 32'hFFFF_FFFF, $urandom_range(1, 50), $urandom, 32'd0};
      forks   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      calm         = 1'b0;
      hold_request = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: registration, instant and saturated sleeps, cancel, empty slots,
      // each run mode, and idle with and without sleepers
      send_command(sclk_pkg::CMD_REGISTER,   5'd0,  32'd0,          2'd0);
      send_command(sclk_pkg::CMD_REGISTER,   5'd0,  32'd0,          2'd0);
      send_command(sclk_pkg::CMD_REGISTER,   5'd0,  32'd0,          2'd0);
      send_command(sclk_pkg::CMD_QUERY,      5'd31, 32'd0,          2'd0);
      send_command(sclk_pkg::CMD_SLEEP,      5'd0,  32'd0,          2'd0);
      send_command(sclk_pkg::CMD_SLEEP,      5'd1,  32'd5,          2'd0);
      send_command(sclk_pkg::CMD_SLEEP,      5'd2,  32'hFFFF_FFFF,  2'd0);
      send_command(sclk_pkg::CMD_SLEEP,      5'd2,  32'd7,          2'd0);
      send_command(sclk_pkg::CMD_CANCEL,     5'd2,  32'd0,          2'd0);
      send_command(sclk_pkg::CMD_UNREGISTER, 5'd31, 32'd0,          2'd0);
      send_command(sclk_pkg::CMD_SLEEP,      5'd30, 32'd4,          2'd0);
      send_command(sclk_pkg::CMD_CANCEL,     5'd29, 32'd0,          2'd0);
      send_command(sclk_pkg::CMD_RUN,        5'd0,  32'd0,          2'd1);
      send_command(sclk_pkg::CMD_SLEEP,      5'd0,  32'd3,          2'd0);
      send_command(sclk_pkg::CMD_RUN,        5'd0,  32'hFFFF_FFFF,  2'd0);
      send_command(sclk_pkg::CMD_IDLE,       5'd0,  32'd0,          2'd0);
      send_command(sclk_pkg::CMD_RUN,        5'd0,  32'd0,          2'd2);
      send_command(sclk_pkg::CMD_IDLE,       5'd0,  32'd0,          2'd0);
      send_command(sclk_pkg::CMD_RUN,        5'd0,  32'd10,         2'd3);
      send_command(sclk_pkg::CMD_NONE,       5'd0,  32'd0,          2'd0);
      send_command(sclk_pkg::CMD_UNREGISTER, 5'd1,  32'd0,          2'd0);
      send_command(sclk_pkg::CMD_IDLE,       5'd0,  32'd0,          2'd0);
      send_command(sclk_pkg::CMD_QUERY,      5'd0,  32'hFFFF_FFFF,  2'd3);

      // random phases, each under its own register setting
      for (int p = 0; p < 6; p++) begin
         drain();
         csr_write(sclk_pkg::REG_TIME_ORIGIN,  origins[p]);
         csr_write(sclk_pkg::REG_IDLE_JUMP,    jumps[p]);
         csr_write(sclk_pkg::REG_NO_FORK_MODE, {31'b0, forks[p]});
         calm = (p == 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 10) hold_request = 1'b1;
            if (p == 3 && i == 40) drain();
            send_random(p == 2 && i < 50);
         end
      end
      calm = 1'b0;

      drain();
      if (error_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
src/sclk_pkg.sv
src/sclk_ram.sv
src/sclk_csr.sv
src/simulated_clock_sleep_table.sv
test/sclk_table_checker.sv
test/tb_simulated_clock_sleep_table.sv
